// ===== src/eads_pkg.sv =====
// Shared types and constants for the edge-aware depth smoother.
// No dependencies; imported by eads_ram, eads_filter and the top level.
package eads_pkg;

  localparam int DEPTH_BITS    = 16;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int DIM_BITS      = 11;
  localparam int ROW_BITS      = 10;
  localparam int HEIGHT_MAX    = 1024;
  localparam int DIM_MIN       = 5;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_STEP     = 2'd2;

  localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = 11'd640;
  localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = 11'd480;
  localparam logic [DEPTH_BITS-1:0] STEP_RESET   = 16'd200;

  typedef logic [DEPTH_BITS-1:0] depth_t;

  typedef struct packed {
    logic   ok;
    depth_t depth;
  } sample_t;

  typedef struct packed {
    depth_t depth;
    logic   ok;
  } result_t;

  localparam int SAMPLE_BITS = $bits(sample_t);

endpackage

// ===== src/eads_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Defaults come from eads_pkg; no other dependencies.
module eads_ram #(
  parameter int WIDTH = eads_pkg::SAMPLE_BITS,
  parameter int DEPTH = eads_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/eads_filter.sv =====
// 3x3 binomial smoothing datapath with edge and validity gating.
// Depends on eads_pkg for sample and result types.
module eads_filter (
  input  eads_pkg::sample_t [8:0] window,
  input  eads_pkg::depth_t        max_step,
  input  logic                    interior,
  output eads_pkg::result_t       result
);
  import eads_pkg::*;

  localparam int SUM_BITS = DEPTH_BITS + 4;
  // 1-2-1 by 1-2-1 weights as left shifts
  localparam logic [1:0] KERNEL_SHIFT [9] = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd1, 2'd0, 2'd1,
                                              2'd0};

  logic [SUM_BITS-1:0] sum;
  logic                smooth;
  depth_t              centre;
  depth_t              diff;

  always_comb begin
    centre = window[4].depth;
    sum    = '0;
    smooth = interior;
    diff   = '0;
    for (int k = 0; k < 9; k++) begin
      diff = (window[k].depth > centre) ? window[k].depth - centre : centre - window[k].depth;
      if (!window[k].ok || (diff > max_step)) begin
        smooth = 1'b0;
      end
      sum = sum + (SUM_BITS'(window[k].depth) << KERNEL_SHIFT[k]);
    end
    if (smooth) begin
      result.depth = sum[SUM_BITS-1:4];
      result.ok    = 1'b1;
    end else begin
      result.depth = centre;
      result.ok    = window[4].ok;
    end
  end

endmodule

// ===== src/edge_aware_depth_smoother.sv =====
// Edge-aware 3x3 depth smoother: counters, line stores, window and output stage.
// Depends on eads_pkg, eads_ram and eads_filter.
//
// Usage:
//  Slave stream carries one raster-order depth sample per transaction; tuser marks
//  the sample valid and flags bubble items that carry no pixel and only drain the
//  tail of a frame after its last pixel. Master stream returns the centre pixel,
//  smoothed or passed through, with tlast on the last pixel of the frame.
//  Each result belongs to the sample pushed one line and one pixel earlier, so the
//  first W+1 pixels after reset or after a full drain produce nothing.
//  Throughput: one transaction per cycle on both sides unless the master side
//  stalls, fixed by the single line-store read and write per pixel; the RAM read
//  is pipelined with a bypass. A result is offered on master tvalid once the
//  transaction completing its window has passed the input register, window stage
//  and output register. When the master side stalls, the stages ahead of the
//  output register keep filling; s_tready drops once every stage holds work.
//  Reset (rst, synchronous) clears counters, window and the pipeline and restores
//  the register defaults; line-store contents are not cleared and need no pass.
//  Configuration is written through cfg_wen/cfg_idx/cfg_wdata while idle.
module edge_aware_depth_smoother #(
  parameter int MAX_WIDTH = eads_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [eads_pkg::DEPTH_BITS-1:0]    s_tdata,   // depth_in
  input  logic [1:0]                         s_tuser,   // [0] sample_ok, [1] bubble
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [eads_pkg::DEPTH_BITS-1:0]    m_tdata,   // depth_out
  output logic [0:0]                         m_tuser,   // [0] out_ok
  output logic                               m_tlast,   // frame_end
  input  logic                               cfg_wen,
  input  logic [eads_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [eads_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import eads_pkg::*;

  localparam int DIM_CAP     = (1 << DIM_BITS) - 1;
  localparam int WIDTH_CAP_I = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP;
  localparam logic [DIM_BITS-1:0] WIDTH_CAP  = DIM_BITS'(WIDTH_CAP_I);
  localparam logic [DIM_BITS-1:0] HEIGHT_CAP = DIM_BITS'(HEIGHT_MAX);
  localparam logic [DIM_BITS-1:0] DIM_LOW    = DIM_BITS'(DIM_MIN);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_WIDTH - 1);
  localparam int PW = DIM_BITS + 1;

  // configuration registers
  logic [DIM_BITS-1:0] frame_width;
  logic [DIM_BITS-1:0] frame_height;
  depth_t              max_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      max_step     <= STEP_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width  <= cfg_wdata[DIM_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_wdata[DIM_BITS-1:0];
        REG_MAX_STEP:     max_step     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [DIM_BITS-1:0] width_used;
  logic [DIM_BITS-1:0] height_used;

  assign width_used  = (frame_width < DIM_LOW) ? DIM_LOW :
                       (frame_width > WIDTH_CAP) ? WIDTH_CAP : frame_width;
  assign height_used = (frame_height < DIM_LOW) ? DIM_LOW :
                       (frame_height > HEIGHT_CAP) ? HEIGHT_CAP : frame_height;

  // handshake chain
  logic accept, out_move, s2_free, s1_free;
  logic s1_push, s2_valid;

  assign out_move = !m_tvalid || m_tready;
  assign s2_free  = !s2_valid || out_move;
  assign s1_free  = !s1_push || s2_free;
  assign s_tready = s1_free;
  assign accept   = s_tvalid && s_tready;

  // position counters and pending count
  logic [DIM_BITS-1:0] col, col_next;
  logic [ROW_BITS-1:0] row, row_next;
  logic [PW-1:0]       pending, pending_next;
  logic [PW-1:0]       full, pend_eff, col_inc;
  logic [DIM_BITS-1:0] row_inc;
  logic                at_start, is_bubble;

  logic                push, emit;
  logic [DIM_BITS-1:0] push_col, emit_row;
  sample_t             item;
  logic [AW-1:0]       addr;
  logic                fwd;

  assign full      = {1'b0, width_used} + PW'(1);
  assign pend_eff  = (pending > full) ? full : pending;
  assign at_start  = (col == '0) && (row == '0);
  assign is_bubble = s_tuser[1];
  assign col_inc   = {1'b0, col} + PW'(1);
  assign row_inc   = DIM_BITS'(row) + DIM_BITS'(1);

  always_comb begin
    push         = 1'b0;
    emit         = 1'b0;
    push_col     = col;
    emit_row     = DIM_BITS'(row);
    item         = '0;
    pending_next = pending;
    col_next     = col;
    row_next     = row;
    if (accept) begin
      if (is_bubble) begin
        // drain only from the start of a frame with pixels still pending
        if (at_start && (pend_eff != '0)) begin
          push         = 1'b1;
          emit         = 1'b1;
          push_col     = DIM_BITS'(full - pend_eff);
          emit_row     = height_used;
          pending_next = pend_eff - PW'(1);
        end
      end else begin
        push       = 1'b1;
        emit       = (pend_eff == full);
        item.ok    = s_tuser[0];
        item.depth = s_tdata;
        if (pend_eff == full) begin
          pending_next = full;
        end else if (at_start && (pend_eff != '0)) begin
          // abandoned drain: drop the old tail
          pending_next = PW'(1);
        end else begin
          pending_next = pend_eff + PW'(1);
        end
        if (col_inc >= {1'b0, width_used}) begin
          col_next = '0;
          if (row_inc >= height_used) begin
            row_next = '0;
          end else begin
            row_next = row_inc[ROW_BITS-1:0];
          end
        end else begin
          col_next = col_inc[DIM_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      pending <= '0;
    end else begin
      col     <= col_next;
      row     <= row_next;
      pending <= pending_next;
    end
  end

  assign addr = (32'(push_col) >= 32'(MAX_WIDTH)) ? ADDR_LAST : AW'(push_col);

  // line stores: mid holds the previous line, top the one before
  logic [AW-1:0]       s1_addr;
  sample_t             s1_item, s1_fwd_mid, s1_fwd_top;
  logic                s1_emit, s1_fwd;
  logic [DIM_BITS-1:0] s1_col, s1_row;
  sample_t             mid_rdata, top_rdata, mid_cur, top_cur;
  logic                ram_we;

  assign ram_we = s1_push && s2_free;
  // same column written back this edge: forward instead of the stale RAM word
  assign fwd    = push && ram_we && (s1_addr == addr);

  eads_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_mid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (s1_item),
    .re    (push),
    .raddr (addr),
    .rdata (mid_rdata)
  );

  eads_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_top_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (mid_cur),
    .re    (push),
    .raddr (addr),
    .rdata (top_rdata)
  );

  assign mid_cur = s1_fwd ? s1_fwd_mid : mid_rdata;
  assign top_cur = s1_fwd ? s1_fwd_top : top_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_push <= 1'b0;
      s1_fwd  <= 1'b0;
    end else if (s1_free) begin
      s1_push <= push;
      s1_fwd  <= fwd;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_emit    <= emit;
      s1_item    <= item;
      s1_addr    <= addr;
      s1_col     <= push_col;
      s1_row     <= emit_row;
      s1_fwd_mid <= s1_item;
      s1_fwd_top <= mid_cur;
    end
  end

  // output position of the window centre
  logic                c_zero;
  logic [DIM_BITS-1:0] oc, orow;
  logic [PW-1:0]       orow_raw, orow_fix;
  logic                interior, frame_end;

  assign c_zero   = (s1_col == '0);
  assign oc       = c_zero ? width_used - DIM_BITS'(1) : s1_col - DIM_BITS'(1);
  assign orow_raw = {1'b0, s1_row} - (c_zero ? PW'(2) : PW'(1));
  assign orow_fix = orow_raw[PW-1] ? orow_raw + {1'b0, height_used} : orow_raw;
  assign orow     = orow_fix[DIM_BITS-1:0];

  assign interior  = (oc >= DIM_BITS'(2)) && (({1'b0, oc} + PW'(2)) < {1'b0, width_used}) &&
                     (orow >= DIM_BITS'(2)) &&
                     (({1'b0, orow} + PW'(2)) < {1'b0, height_used});
  assign frame_end = (oc == width_used - DIM_BITS'(1)) &&
                     (orow == height_used - DIM_BITS'(1));

  // window stage
  sample_t [8:0] window;
  logic          s2_interior, s2_frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      window   <= '0;
    end else if (s2_free) begin
      s2_valid <= s1_push && s1_emit;
      if (s1_push) begin
        window[0] <= window[1];
        window[1] <= window[2];
        window[2] <= top_cur;
        window[3] <= window[4];
        window[4] <= window[5];
        window[5] <= mid_cur;
        window[6] <= window[7];
        window[7] <= window[8];
        window[8] <= s1_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_interior  <= interior;
      s2_frame_end <= frame_end;
    end
  end

  result_t result;

  eads_filter u_filter (
    .window   (window),
    .max_step (max_step),
    .interior (s2_interior),
    .result   (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_move) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move) begin
      m_tdata    <= result.depth;
      m_tuser[0] <= result.ok;
      m_tlast    <= s2_frame_end;
    end
  end

  // hold the window while its result waits for the output register
  assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_free |=> $stable(window))
    else $error("window changed under a stalled result");

  assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> s1_push)
    else $error("line-store bypass without a pending push");

  assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_frame_end |-> !s2_interior)
    else $error("last pixel of a frame marked as interior");

  assert property (@(posedge clk) disable iff (rst)
    accept && !is_bubble |=> pending != '0)
    else $error("real pixel left nothing pending");

endmodule
